/* src/mtws_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-task watchdog supervisor package
// Shared widths, codes, word types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mtws_pkg;

  localparam int NUM_TASKS_DEF = 4;
  localparam int TICK_W        = 32;
  localparam int TASK_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ALIVE    = 2'd1,
    OP_REGISTER = 2'd2,
    OP_CHECK    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STARTUP_DONE  = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1
  } reg_idx_t;

  typedef struct packed {
    op_t               opcode;
    logic [TASK_W-1:0] task_id;
  } in_word_t;

  typedef struct packed {
    logic              refresh;
    logic              fault;
    logic [TASK_W-1:0] fault_task;
  } out_word_t;

  typedef struct packed {
    logic exec;
    logic scan_start;
    logic scan_read;
    logic scan_next;
    logic res_clear;
    logic res_refresh;
    logic res_fault;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic startup_done;
    logic expired;
    logic last_task;
    logic out_free;
  } stat_t;

endpackage

/* src/mtws_ctrl.sv */
// ----------------------------------------------------------------------------
// Multi-task watchdog supervisor controller
// Sequences one word at a time: execute, scan the task table, hand over result.
// ----------------------------------------------------------------------------
module mtws_ctrl
  import mtws_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  op_t      in_op,
  input  stat_t    stat,
  output cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec = 1'b1;
          if (in_op == OP_CHECK && stat.startup_done) begin
            cmd.scan_start = 1'b1;
            state_next     = S_READ;
          end else if (in_op == OP_CHECK) begin
            cmd.res_refresh = 1'b1;
            state_next      = S_RESP;
          end else begin
            cmd.res_clear = 1'b1;
            state_next    = S_RESP;
          end
        end
      end
      S_READ: begin
        cmd.scan_read = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        if (stat.expired) begin
          cmd.res_fault = 1'b1;
          state_next    = S_RESP;
        end else if (stat.last_task) begin
          cmd.res_refresh = 1'b1;
          state_next      = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_READ;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/mtws_datapath.sv */
// ----------------------------------------------------------------------------
// Multi-task watchdog supervisor datapath
// Tick counter, task table, configuration registers, compare and result words.
// ----------------------------------------------------------------------------
module mtws_datapath
  import mtws_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_word_t              in_word,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic [TICK_W-1:0] last_alive [NUM_TASKS];
  logic [NUM_TASKS-1:0] alive_vld;
  logic [NUM_TASKS-1:0] task_enabled;

  logic              startup_done;
  logic [TICK_W-1:0] timeout_ticks;
  logic [TICK_W-1:0] tick_now;

  logic [IDX_W-1:0]  idx;
  logic [TICK_W-1:0] rd_data;
  logic              rd_vld;
  logic              rd_en;
  out_word_t         res;

  logic [IDX_W-1:0]  wr_idx;
  logic              id_ok;
  logic [TICK_W-1:0] elapsed;

  assign wr_idx  = IDX_W'(in_word.task_id);
  assign id_ok   = 32'(in_word.task_id) < NUM_TASKS;
  assign elapsed = tick_now - (rd_vld ? rd_data : '0);

  assign stat.startup_done = startup_done;
  assign stat.expired      = rd_en && (elapsed > timeout_ticks);
  assign stat.last_task    = (idx == IDX_W'(NUM_TASKS - 1));
  assign stat.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_done  <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STARTUP_DONE:  startup_done  <= cfg_data[0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now     <= '0;
      alive_vld    <= '0;
      task_enabled <= '0;
    end else if (cmd.exec) begin
      case (in_word.opcode)
        OP_TICK: tick_now <= tick_now + TICK_W'(1);
        OP_ALIVE: begin
          if (id_ok) begin
            alive_vld[wr_idx] <= 1'b1;
          end
        end
        OP_REGISTER: begin
          if (id_ok) begin
            task_enabled[wr_idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && in_word.opcode == OP_ALIVE && id_ok) begin
      last_alive[wr_idx] <= tick_now;
    end
    if (cmd.scan_read) begin
      rd_data <= last_alive[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.scan_read) begin
      rd_vld <= alive_vld[idx];
      rd_en  <= task_enabled[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res <= '0;
    end else if (cmd.res_refresh) begin
      res <= '{refresh: 1'b1, fault: 1'b0, fault_task: '0};
    end else if (cmd.res_fault) begin
      res.refresh    <= 1'b0;
      res.fault      <= 1'b1;
      res.fault_task <= TASK_W'(idx);
    end
    if (cmd.out_load) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* src/multi_task_watchdog_supervisor.sv */
// A tick, alive, register or early check word is registered into the result word on acceptance, and the result
// is loaded into the output register once the output is free. A check after startup reads and then compares
// each task from task 0 on, as the last-alive table has one read port with registered data, and it stops at
// the first enabled task that has expired or after the last task. A new word is taken once the previous
// result has been loaded into the output register; a new word is taken while that result waits at the output.
// Synchronous reset clears the tick counter, registrations and alive marks, and restores the registers.
// ----------------------------------------------------------------------------
// Multi-task watchdog supervisor
// Checks registered tasks for missed alive reports against a shared timeout.
// ----------------------------------------------------------------------------
module multi_task_watchdog_supervisor
  import mtws_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mtws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_word.opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtws_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* src/mtws_checker.sv */
// ----------------------------------------------------------------------------
// Multi-task watchdog supervisor checker
// Port-level properties of the result words and the input handshake.
// ----------------------------------------------------------------------------
module mtws_checker
  import mtws_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_no_refresh_with_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.refresh && out_word.fault))
    else $error("A result word both refreshes and reports a fault.");

  a_task_zero_without_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.fault) |-> (out_word.fault_task == '0))
    else $error("A fault task is given without a fault.");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second word was offered acceptance straight after the first.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("A stalled result word changed or vanished.");

endmodule

bind multi_task_watchdog_supervisor mtws_checker u_mtws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
